[rtl/pba_pkg.sv]
// Shared constants, types and handshake structs of the page bitmap allocator.
package pba_pkg;

  localparam int AddrW       = 64;
  localparam int SizeW       = 28;
  localparam int MapBits     = 64;
  localparam int BitIdxW     = 6;
  localparam int GroupShift  = 18;
  localparam int PageShift   = 12;
  localparam int GroupW      = SizeW - GroupShift;
  localparam int DefMapWords = 512;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 64;
  localparam int StatusW     = 2;

  localparam logic [CfgIdxW-1:0] CfgPoolBase = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPoolSize = 1'd1;

  typedef enum logic [StatusW-1:0] {
    StatOk       = 2'd0,
    StatFull     = 2'd1,
    StatRange    = 2'd2,
    StatNotAlloc = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    clr_step;
    logic    decode;
    logic    rd_scan;
    logic    rd_free;
    logic    scan_next;
    logic    alloc_commit;
    logic    free_commit;
    logic    res_load;
    status_e res_status;
    logic    res_grant;
  } pba_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic op_free;
    logic clr_last;
    logic scan_empty;
    logic scan_last;
    logic word_full;
    logic range_bad;
    logic beyond_map;
    logic bit_set;
  } pba_stat_t;

endpackage

[rtl/pba_datapath.sv]
// Datapath of the page bitmap allocator: config, bitmap memory, scan and result registers.
module pba_datapath import pba_pkg::*; #(
  parameter int MapWords = DefMapWords
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_operation_i,
  input  logic [AddrW-1:0]    in_page_address_i,
  input  pba_cmd_t            cmd_i,
  output pba_stat_t           stat_o,
  output logic [StatusW-1:0]  out_status_o,
  output logic [AddrW-1:0]    out_granted_address_o
);

  localparam int WordW = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int CntW  = $clog2(MapWords + 1);

  logic [AddrW-1:0]   base_q;
  logic [SizeW-1:0]   size_q;
  logic               op_q;
  logic [AddrW-1:0]   addr_q;
  logic [WordW-1:0]   last_q;
  logic [WordW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]    rem_q;
  logic [WordW-1:0]   clr_q;
  logic [AddrW-1:0]   off_q;
  logic               below_q;
  logic [MapBits-1:0] rdata_q;
  logic [BitIdxW-1:0] j_q;
  status_e            res_status_q;
  logic [AddrW-1:0]   res_addr_q;

  logic [MapBits-1:0] mem_q [MapWords];

  logic [GroupW-1:0]  grp_all;
  logic [CntW-1:0]    group_cnt;
  logic [WordW-1:0]   scan_start;
  logic [CntW:0]      idx_inc;
  logic [GroupW-1:0]  grp_free;
  logic [WordW-1:0]   free_idx;
  logic [MapBits-1:0] free_mask;
  logic [MapBits-1:0] low_onehot;
  logic [BitIdxW-1:0] j_enc;
  logic [AddrW-1:0]   grant;
  logic               mem_we;
  logic [WordW-1:0]   mem_waddr;
  logic [MapBits-1:0] mem_wdata;
  logic               mem_re;
  logic [WordW-1:0]   mem_raddr;

  // Group count, capped at the map depth.
  always_comb begin
    grp_all = size_q[SizeW-1:GroupShift];
    if (int'(grp_all) > MapWords) begin
      group_cnt = CntW'(MapWords);
    end else begin
      group_cnt = CntW'(grp_all);
    end
  end

  // A stale last word restarts the scan at word zero.
  assign scan_start = (CntW'(last_q) < group_cnt) ? last_q : '0;

  always_comb begin
    idx_inc = (CntW+1)'(idx_q) + (CntW+1)'(1);
    if (idx_inc == {1'b0, group_cnt}) begin
      idx_d = '0;
    end else begin
      idx_d = WordW'(idx_inc);
    end
  end

  assign grp_free  = off_q[SizeW-1:GroupShift];
  assign free_idx  = WordW'(grp_free);
  assign free_mask = MapBits'(1) << off_q[GroupShift-1:PageShift];

  // Lowest clear bit of the read word: ~w & (w + 1) isolates it.
  assign low_onehot = ~rdata_q & (rdata_q + MapBits'(1));

  always_comb begin
    j_enc = '0;
    for (int k = 0; k < MapBits; k++) begin
      if (low_onehot[k]) begin
        j_enc = j_enc | BitIdxW'(k);
      end
    end
  end

  assign grant = base_q + ((AddrW'(idx_q) << GroupShift) | (AddrW'(j_q) << PageShift));

  assign stat_o.op_free    = op_q;
  assign stat_o.clr_last   = (clr_q == WordW'(MapWords - 1));
  assign stat_o.scan_empty = (group_cnt == '0);
  assign stat_o.scan_last  = (rem_q == CntW'(1));
  assign stat_o.word_full  = &rdata_q;
  assign stat_o.range_bad  = below_q || (off_q[AddrW-1:SizeW] != '0) ||
                             (off_q[SizeW-1:0] >= size_q);
  assign stat_o.beyond_map = (int'(grp_free) >= MapWords);
  assign stat_o.bit_set    = |(rdata_q & free_mask);

  // Memory port steering.
  always_comb begin
    mem_we    = cmd_i.clr_step | cmd_i.alloc_commit | cmd_i.free_commit;
    mem_waddr = clr_q;
    mem_wdata = '0;
    if (cmd_i.alloc_commit) begin
      mem_waddr = idx_q;
      mem_wdata = rdata_q | low_onehot;
    end else if (cmd_i.free_commit) begin
      mem_waddr = free_idx;
      mem_wdata = rdata_q & ~free_mask;
    end
    mem_re    = cmd_i.rd_scan | cmd_i.rd_free;
    mem_raddr = cmd_i.rd_scan ? idx_q : free_idx;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      size_q <= '0;
      last_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgPoolBase: base_q <= cfg_wdata_i;
          CfgPoolSize: size_q <= cfg_wdata_i[SizeW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + WordW'(1);
      end
      if (cmd_i.alloc_commit) begin
        last_q <= idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_operation_i;
      addr_q <= in_page_address_i;
      idx_q  <= scan_start;
      rem_q  <= group_cnt;
    end
    if (cmd_i.scan_next) begin
      idx_q <= idx_d;
      rem_q <= rem_q - CntW'(1);
    end
    if (cmd_i.decode) begin
      off_q   <= addr_q - base_q;
      below_q <= addr_q < base_q;
    end
    if (cmd_i.alloc_commit) begin
      j_q <= j_enc;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_addr_q   <= cmd_i.res_grant ? grant : '0;
    end
  end

  assign out_status_o          = res_status_q;
  assign out_granted_address_o = res_addr_q;

endmodule

[rtl/pba_ctrl.sv]
// Controller state machine of the page bitmap allocator.
module pba_ctrl import pba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pba_stat_t stat_i,
  output pba_cmd_t  cmd_o
);

  localparam logic [2:0] StClear    = 3'd0;
  localparam logic [2:0] StIdle     = 3'd1;
  localparam logic [2:0] StDecode   = 3'd2;
  localparam logic [2:0] StAllocRd  = 3'd3;
  localparam logic [2:0] StAllocEv  = 3'd4;
  localparam logic [2:0] StAllocOut = 3'd5;
  localparam logic [2:0] StFreeChk  = 3'd6;
  localparam logic [2:0] StFreeEv   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDecode;
        end
      end
      StDecode: begin
        if (stat_i.op_free) begin
          cmd_o.decode = 1'b1;
          state_d      = StFreeChk;
        end else if (stat_i.scan_empty) begin
          if (can_load) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = StatFull;
            state_d          = StIdle;
          end
        end else begin
          cmd_o.rd_scan = 1'b1;
          state_d       = StAllocEv;
        end
      end
      StAllocRd: begin
        cmd_o.rd_scan = 1'b1;
        state_d       = StAllocEv;
      end
      StAllocEv: begin
        if (!stat_i.word_full) begin
          cmd_o.alloc_commit = 1'b1;
          state_d            = StAllocOut;
        end else if (stat_i.scan_last) begin
          if (can_load) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = StatFull;
            state_d          = StIdle;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = StAllocRd;
        end
      end
      StAllocOut: begin
        if (can_load) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = StatOk;
          cmd_o.res_grant  = 1'b1;
          state_d          = StIdle;
        end
      end
      StFreeChk: begin
        if (stat_i.range_bad) begin
          if (can_load) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = StatRange;
            state_d          = StIdle;
          end
        end else if (stat_i.beyond_map) begin
          if (can_load) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = StatNotAlloc;
            state_d          = StIdle;
          end
        end else begin
          cmd_o.rd_free = 1'b1;
          state_d       = StFreeEv;
        end
      end
      StFreeEv: begin
        if (can_load) begin
          cmd_o.res_load = 1'b1;
          if (stat_i.bit_set) begin
            cmd_o.free_commit = 1'b1;
            cmd_o.res_status  = StatOk;
          end else begin
            cmd_o.res_status  = StatNotAlloc;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/page_bitmap_allocator_top.sv]
// Top level of the page bitmap allocator: 4 KiB page grant and release over a bitmap.
// An allocate scans bitmap words from the last granted word, with wrap, reading at most one
// word per group; an empty pool reports full without a read; a free checks range, then bit.
// One item at a time: the next beat is taken only once the result is registered, and each
// bitmap word read is evaluated before the next word is read.
// Reset (async, active low) clears config and last word, then sweeps all MapWords words
// of the bitmap memory, writing zeros; no input beat is taken until the sweep ends.
module page_bitmap_allocator_top import pba_pkg::*; #(
  parameter int MapWords = DefMapWords
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_operation_i,
  input  logic [AddrW-1:0]    in_page_address_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  out_status_o,
  output logic [AddrW-1:0]    out_granted_address_o
);

  pba_cmd_t  cmd;
  pba_stat_t stat;

  // Sequencer: clear sweep, word scan with wrap, free checks, and the output
  // register's valid. A finished result waits in the output register while the
  // controller is free to take the next beat.
  pba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Bitmap memory (one read, one write port, registered read data), scan pointer,
  // free offset check, lowest-clear-bit encoder and the result payload register.
  pba_datapath #(
    .MapWords (MapWords)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_operation_i        (in_operation_i),
    .in_page_address_i     (in_page_address_i),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .out_status_o          (out_status_o),
    .out_granted_address_o (out_granted_address_o)
  );

endmodule

[rtl/pba_checker.sv]
// Port-level checks of the page bitmap allocator, bound to the top level.
module pba_checker import pba_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [StatusW-1:0] out_status_o,
  input logic [AddrW-1:0]   out_granted_address_o
);

  // Hold a stalled result beat unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_status_o) && $stable(out_granted_address_o))
    else $error("result beat changed while stalled");

  // Drive a zero address on every result whose status is not OK.
  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != StatOk) |-> out_granted_address_o == '0)
    else $error("nonzero address on a failed result");

  // Drop ready after a request beat: one item in flight at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

endmodule

bind page_bitmap_allocator_top pba_checker u_pba_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_valid_i),
  .in_ready_o            (in_ready_o),
  .out_valid_o           (out_valid_o),
  .out_ready_i           (out_ready_i),
  .out_status_o          (out_status_o),
  .out_granted_address_o (out_granted_address_o)
);
